>>> hdl/tkd_pkg.sv
// types, constants and helpers shared by the key decoder and cursor blocks
package tkd_pkg;

  localparam int unsigned MAX_SCREEN  = 1023;
  localparam int unsigned SIZE_W      = 10;
  localparam int unsigned KEYQ_DEPTH  = 2;

  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] CTRL_MASK  = 8'h1f;
  localparam logic [7:0] QUIT_BYTE  = 8'h71 & CTRL_MASK;
  localparam logic [7:0] TILDE_BYTE = 8'h7e;
  localparam logic [7:0] LBRK_BYTE  = 8'h5b;
  localparam logic [7:0] OH_BYTE    = 8'h4f;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_1       = 8'h31;
  localparam logic [7:0] CH_3       = 8'h33;
  localparam logic [7:0] CH_4       = 8'h34;
  localparam logic [7:0] CH_5       = 8'h35;
  localparam logic [7:0] CH_6       = 8'h36;
  localparam logic [7:0] CH_7       = 8'h37;
  localparam logic [7:0] CH_8       = 8'h38;
  localparam logic [7:0] CH_9       = 8'h39;

  localparam logic       EV_BYTE    = 1'b0;
  localparam logic       EV_TIMEOUT = 1'b1;

  localparam logic       REG_ROWS   = 1'b0;
  localparam logic       REG_COLS   = 1'b1;

  localparam logic [SIZE_W-1:0] ROWS_RESET = 10'd24;
  localparam logic [SIZE_W-1:0] COLS_RESET = 10'd80;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_BRACKET,
    PH_OH,
    PH_OTHER,
    PH_TILDE
  } phase_t;

  typedef enum logic [3:0] {
    K_PLAIN = 4'd0,
    K_LEFT  = 4'd1,
    K_RIGHT = 4'd2,
    K_UP    = 4'd3,
    K_DOWN  = 4'd4,
    K_DEL   = 4'd5,
    K_HOME  = 4'd6,
    K_END   = 4'd7,
    K_PGUP  = 4'd8,
    K_PGDN  = 4'd9,
    K_QUIT  = 4'd10
  } key_kind_t;

  typedef struct packed {
    key_kind_t  kind;
    logic [7:0] kbyte;
  } key_t;

  // highest usable coordinate for a size register
  function automatic logic [SIZE_W-1:0] limit_of(input logic [SIZE_W-1:0] size);
    logic [16:0] s;
    logic [16:0] lim;
    s = {7'd0, size};
    if (s == 17'd0) s = 17'd1;
    if (s > 17'(MAX_SCREEN)) s = 17'(MAX_SCREEN);
    lim = s - 17'd1;
    return lim[SIZE_W-1:0];
  endfunction

endpackage

>>> hdl/terminal_key_decoder_cursor.sv
// top level: vt100 key decoder feeding a clamped cursor
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | push / full          | in_event_kind, in_rx_byte
//  result   | pop / empty          | out_key_kind, out_key_byte, out_cursor_col/row
//  config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// one item per cycle when the result side keeps popping; a key enters the key queue at
// the accepting edge and moves into the result register once that is empty or popped
// the two-entry key queue lets the decoder keep taking items while a result waits
// full rises only once the key queue holds two keys; items that make no key still
// need a free slot to be taken
// synchronous active-low reset: decoder idle, cursor at 0,0, rows 24, cols 80
module terminal_key_decoder_cursor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_event_kind,
  input  logic [7:0] in_rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] out_key_kind,
  output logic [7:0] out_key_byte,
  output logic [9:0] out_cursor_col,
  output logic [9:0] out_cursor_row,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data
);
  import tkd_pkg::*;

  logic acc;
  logic key_push;
  key_t dec_key;
  key_t q_key;
  logic q_full, q_empty;
  logic key_take;
  logic res_valid;

  assign acc   = push && !q_full;
  assign full  = q_full;
  assign empty = !res_valid;

  tkd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .event_kind (in_event_kind),
    .rx_byte    (in_rx_byte),
    .key_push   (key_push),
    .key        (dec_key)
  );

  tkd_keyq u_keyq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (key_push),
    .wr_key  (dec_key),
    .rd_en   (key_take),
    .rd_key  (q_key),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  tkd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_valid (!q_empty),
    .key       (q_key),
    .key_take  (key_take),
    .res_pop   (pop),
    .res_valid (res_valid),
    .res_kind  (out_key_kind),
    .res_byte  (out_key_byte),
    .res_col   (out_cursor_col),
    .res_row   (out_cursor_row)
  );

endmodule

>>> hdl/tkd_front.sv
// escape sequence decoder: turns accepted bytes and timeouts into keys
module tkd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          event_kind,
  input  logic [7:0]    rx_byte,
  output logic          key_push,
  output tkd_pkg::key_t key
);
  import tkd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       emit;
  key_kind_t  kind;
  logic [7:0] plain;
  logic       is_digit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    kind      = K_PLAIN;
    plain     = ESC_BYTE;
    if (acc) begin
      if (event_kind == EV_TIMEOUT) begin
        if (phase_r != PH_IDLE) begin
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (rx_byte == ESC_BYTE) begin
              phase_nxt = PH_ESC;
            end else begin
              emit = 1'b1;
              if (rx_byte == QUIT_BYTE) kind = K_QUIT;
              else plain = rx_byte;
            end
          end
          PH_ESC: begin
            if (rx_byte == LBRK_BYTE) phase_nxt = PH_BRACKET;
            else if (rx_byte == OH_BYTE) phase_nxt = PH_OH;
            else phase_nxt = PH_OTHER;
          end
          PH_BRACKET: begin
            if (is_digit) begin
              held_nxt  = rx_byte;
              phase_nxt = PH_TILDE;
            end else begin
              phase_nxt = PH_IDLE;
              emit      = 1'b1;
              unique case (rx_byte)
                CH_A:    kind = K_UP;
                CH_B:    kind = K_DOWN;
                CH_C:    kind = K_RIGHT;
                CH_D:    kind = K_LEFT;
                CH_H:    kind = K_HOME;
                CH_F:    kind = K_END;
                default: kind = K_PLAIN;
              endcase
            end
          end
          PH_OH: begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            unique case (rx_byte)
              CH_H:    kind = K_HOME;
              CH_F:    kind = K_END;
              default: kind = K_PLAIN;
            endcase
          end
          PH_TILDE: begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            if (rx_byte == TILDE_BYTE) begin
              unique case (held_r)
                CH_1, CH_7: kind = K_HOME;
                CH_4, CH_8: kind = K_END;
                CH_3:       kind = K_DEL;
                CH_5:       kind = K_PGUP;
                CH_6:       kind = K_PGDN;
                default:    kind = K_PLAIN;
              endcase
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
          end
        endcase
      end
    end
  end

  assign key_push  = emit;
  assign key.kind  = kind;
  assign key.kbyte = (kind == K_PLAIN) ? plain : 8'd0;

  a_timeout_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && event_kind == EV_TIMEOUT |=> phase_r == PH_IDLE)
    else $error("decoder not idle after timeout");

  a_esc_opens: assert property (@(posedge clk) disable iff (!rst_n)
    acc && event_kind == EV_BYTE && phase_r == PH_IDLE && rx_byte == ESC_BYTE
      |-> !key_push)
    else $error("escape byte emitted a key");

  a_seq_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r != PH_IDLE && phase_nxt == PH_IDLE |-> key_push)
    else $error("sequence closed without a key");

endmodule

>>> hdl/tkd_keyq.sv
// short key queue between decoder and cursor stage
module tkd_keyq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  tkd_pkg::key_t wr_key,
  input  logic          rd_en,
  output tkd_pkg::key_t rd_key,
  output logic          q_full,
  output logic          q_empty
);
  import tkd_pkg::*;

  localparam int unsigned PTR_W = (KEYQ_DEPTH > 1) ? $clog2(KEYQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(KEYQ_DEPTH + 1);

  key_t             slot_r [KEYQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(KEYQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  assign q_full  = (cnt_r == CNT_W'(KEYQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_key  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + CNT_W'(1);
    else if (!wr_en && rd_en) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wr_ptr_r] <= wr_key;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !wr_en)
    else $error("key queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !rd_en)
    else $error("key queue underflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(KEYQ_DEPTH))
    else $error("key queue count out of range");

endmodule

>>> hdl/tkd_back.sv
// cursor stage: size registers, clamped cursor and result register
module tkd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [9:0]    cfg_data,
  input  logic          key_valid,
  input  tkd_pkg::key_t key,
  output logic          key_take,
  input  logic          res_pop,
  output logic          res_valid,
  output logic [3:0]    res_kind,
  output logic [7:0]    res_byte,
  output logic [9:0]    res_col,
  output logic [9:0]    res_row
);
  import tkd_pkg::*;

  logic [SIZE_W-1:0] rows_r, cols_r;
  logic [SIZE_W-1:0] col_r, col_nxt;
  logic [SIZE_W-1:0] row_r, row_nxt;
  logic [SIZE_W-1:0] col_lim, row_lim;
  logic              valid_r;
  key_t              key_r;
  logic [SIZE_W-1:0] ocol_r, orow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS) rows_r <= cfg_data;
      else cols_r <= cfg_data;
    end
  end

  assign col_lim  = limit_of(cols_r);
  assign row_lim  = limit_of(rows_r);
  assign key_take = key_valid && (!valid_r || res_pop);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    case (key.kind)
      K_LEFT: begin
        col_nxt = (col_r != '0) ? col_r - SIZE_W'(1) : col_r;
        if (col_nxt > col_lim) col_nxt = col_lim;
      end
      K_RIGHT: col_nxt = (col_r >= col_lim) ? col_lim : col_r + SIZE_W'(1);
      K_UP: begin
        row_nxt = (row_r != '0) ? row_r - SIZE_W'(1) : row_r;
        if (row_nxt > row_lim) row_nxt = row_lim;
      end
      K_DOWN:  row_nxt = (row_r >= row_lim) ? row_lim : row_r + SIZE_W'(1);
      K_HOME:  col_nxt = '0;
      K_END:   col_nxt = col_lim;
      K_PGUP:  row_nxt = '0;
      K_PGDN:  row_nxt = row_lim;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (key_take) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        valid_r <= 1'b1;
      end else if (res_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_take) begin
      key_r  <= key;
      ocol_r <= col_nxt;
      orow_r <= row_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res_kind  = key_r.kind;
  assign res_byte  = key_r.kbyte;
  assign res_col   = ocol_r;
  assign res_row   = orow_r;

  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    key_take |=> valid_r && ocol_r == col_r && orow_r == row_r)
    else $error("result does not match cursor");

  a_home_col: assert property (@(posedge clk) disable iff (!rst_n)
    key_take && key.kind == K_HOME |=> col_r == '0)
    else $error("home did not clear column");

  a_end_col: assert property (@(posedge clk) disable iff (!rst_n)
    key_take && key.kind == K_END |=> col_r == $past(col_lim))
    else $error("end did not reach last column");

  a_no_take_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !res_pop |-> !key_take)
    else $error("result overwritten while waiting");

endmodule

>>> verif/tb.sv
// testbench for terminal_key_decoder_cursor: vt100 key decode and clamped cursor
`timescale 1ns / 1ps

module tb;
  import tkd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned SETTLE_CYC   = 4;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam int unsigned PHASE_COUNT  = 10;

  typedef struct packed {
    logic       is_cfg;
    logic       ev;
    logic [7:0] rx;
    logic       idx;
    logic [9:0] data;
  } feed_t;

  typedef struct packed {
    key_kind_t  kind;
    logic [7:0] kbyte;
    logic [9:0] col;
    logic [9:0] row;
  } key_result_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       in_event_kind = 1'b0;
  logic [7:0] in_rx_byte = 8'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic [3:0] out_key_kind;
  logic [7:0] out_key_byte;
  logic [9:0] out_cursor_col;
  logic [9:0] out_cursor_row;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [9:0] cfg_data = 10'd0;

  feed_t       feed_q[$];
  key_result_t keys_due[$];

  // predictor state
  phase_t      dec_phase = PH_IDLE;
  logic [7:0]  held_digit = 8'd0;
  logic [9:0]  cur_col = 10'd0;
  logic [9:0]  cur_row = 10'd0;
  logic [9:0]  rows_size = ROWS_RESET;
  logic [9:0]  cols_size = COLS_RESET;

  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  int unsigned items_taken = 0;
  int unsigned keys_taken = 0;
  int unsigned drv_wait = 0;
  int unsigned pop_wait = 0;
  int unsigned quiet = 0;
  int unsigned items_queued = 0;

  terminal_key_decoder_cursor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_event_kind  (in_event_kind),
    .in_rx_byte     (in_rx_byte),
    .empty          (empty),
    .pop            (pop),
    .out_key_kind   (out_key_kind),
    .out_key_byte   (out_key_byte),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [9:0] top_of(input logic [9:0] size);
    return (size == 10'd0) ? 10'd0 : size - 10'd1;
  endfunction

  function automatic key_kind_t seq_letter_key(input logic [7:0] b, input logic bracket);
    case (b)
      CH_A: return bracket ? K_UP : K_PLAIN;
      CH_B: return bracket ? K_DOWN : K_PLAIN;
      CH_C: return bracket ? K_RIGHT : K_PLAIN;
      CH_D: return bracket ? K_LEFT : K_PLAIN;
      CH_H: return K_HOME;
      CH_F: return K_END;
      default: return K_PLAIN;
    endcase
  endfunction

  function automatic key_kind_t tilde_digit_key(input logic [7:0] d);
    case (d)
      CH_1, CH_7: return K_HOME;
      CH_4, CH_8: return K_END;
      CH_3: return K_DEL;
      CH_5: return K_PGUP;
      CH_6: return K_PGDN;
      default: return K_PLAIN;
    endcase
  endfunction

  task automatic decode_key(input logic ev, input logic [7:0] b);
    key_kind_t   kind;
    logic [7:0]  plain;
    logic        emit;
    logic [9:0]  clim;
    logic [9:0]  rlim;
    key_result_t r;
    kind = K_PLAIN;
    plain = ESC_BYTE;
    emit = 1'b0;
    if (ev == EV_TIMEOUT) begin
      if (dec_phase != PH_IDLE) begin
        dec_phase = PH_IDLE;
        emit = 1'b1;
      end
    end else begin
      case (dec_phase)
        PH_IDLE: begin
          if (b == ESC_BYTE) begin
            dec_phase = PH_ESC;
          end else begin
            emit = 1'b1;
            if (b == QUIT_BYTE) kind = K_QUIT;
            else plain = b;
          end
        end
        PH_ESC: begin
          if (b == LBRK_BYTE) dec_phase = PH_BRACKET;
          else if (b == OH_BYTE) dec_phase = PH_OH;
          else dec_phase = PH_OTHER;
        end
        PH_BRACKET: begin
          if (b >= CH_0 && b <= CH_9) begin
            held_digit = b;
            dec_phase = PH_TILDE;
          end else begin
            kind = seq_letter_key(b, 1'b1);
            dec_phase = PH_IDLE;
            emit = 1'b1;
          end
        end
        PH_OH: begin
          kind = seq_letter_key(b, 1'b0);
          dec_phase = PH_IDLE;
          emit = 1'b1;
        end
        PH_TILDE: begin
          if (b == TILDE_BYTE) kind = tilde_digit_key(held_digit);
          dec_phase = PH_IDLE;
          emit = 1'b1;
        end
        default: begin
          dec_phase = PH_IDLE;
          emit = 1'b1;
        end
      endcase
    end
    if (emit) begin
      clim = top_of(cols_size);
      rlim = top_of(rows_size);
      // a step from past the edge saturates to the edge
      case (kind)
        K_LEFT: begin
          if (cur_col > 10'd0) cur_col = cur_col - 10'd1;
          if (cur_col > clim) cur_col = clim;
        end
        K_RIGHT: cur_col = (cur_col >= clim) ? clim : cur_col + 10'd1;
        K_UP: begin
          if (cur_row > 10'd0) cur_row = cur_row - 10'd1;
          if (cur_row > rlim) cur_row = rlim;
        end
        K_DOWN: cur_row = (cur_row >= rlim) ? rlim : cur_row + 10'd1;
        K_HOME: cur_col = 10'd0;
        K_END:  cur_col = clim;
        K_PGUP: cur_row = 10'd0;
        K_PGDN: cur_row = rlim;
        default: ;
      endcase
      r.kind = kind;
      r.kbyte = (kind == K_PLAIN) ? plain : 8'd0;
      r.col = cur_col;
      r.row = cur_row;
      keys_due.push_back(r);
    end
  endtask

  // --------------------------------------------------------- driver / monitor

  // every fourth stretch of 128 items runs with no idling
  function automatic int unsigned idle_draw(input int unsigned n);
    return ((n / 128) % 4 == 3) ? 0 : $urandom_range(0, 10);
  endfunction

  always @(posedge clk) begin
    logic  nx_push;
    logic  nx_we;
    feed_t f;
    if (!rst_n) begin
      push <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nx_push = push;
      nx_we = 1'b0;
      if (push && !full) begin
        decode_key(in_event_kind, in_rx_byte);
        items_taken++;
        quiet = 0;
        nx_push = 1'b0;
        drv_wait = idle_draw(items_taken);
      end else if (!push && quiet < 1000) begin
        quiet++;
      end
      if (!nx_push) begin
        if (drv_wait > 0) begin
          drv_wait--;
        end else if (feed_q.size() != 0) begin
          f = feed_q[0];
          if (f.is_cfg) begin
            // size changes only while nothing is in flight
            if (!push && keys_due.size() == 0 && quiet >= SETTLE_CYC) begin
              nx_we = 1'b1;
              cfg_index <= f.idx;
              cfg_data <= f.data;
              if (f.idx == REG_ROWS) rows_size = f.data;
              else cols_size = f.data;
              void'(feed_q.pop_front());
            end
          end else begin
            in_event_kind <= f.ev;
            in_rx_byte <= f.rx;
            nx_push = 1'b1;
            void'(feed_q.pop_front());
          end
        end
      end
      push <= nx_push;
      cfg_we <= nx_we;
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at result %0d: got %0d, want %0d", what, keys_taken, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    logic        nx_pop;
    key_result_t e;
    if (!rst_n) begin
      pop <= 1'b0;
      pop_wait = $urandom_range(0, 10);
    end else begin
      nx_pop = pop;
      if (pop && !empty) begin
        if (keys_due.size() == 0) begin
          flag_mismatch("unexpected key_kind", int'(out_key_kind), -1);
        end else begin
          e = keys_due.pop_front();
          if (out_key_kind !== e.kind)
            flag_mismatch("key_kind", int'(out_key_kind), int'(e.kind));
          if (out_key_byte !== e.kbyte)
            flag_mismatch("key_byte", int'(out_key_byte), int'(e.kbyte));
          if (out_cursor_col !== e.col)
            flag_mismatch("cursor_col", int'(out_cursor_col), int'(e.col));
          if (out_cursor_row !== e.row)
            flag_mismatch("cursor_row", int'(out_cursor_row), int'(e.row));
        end
        keys_taken++;
        pop_wait = idle_draw(keys_taken);
        nx_pop = (pop_wait == 0);
      end else if (!pop) begin
        if (pop_wait > 0) pop_wait--;
        if (pop_wait == 0) nx_pop = 1'b1;
      end
      pop <= nx_pop;
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic add_byte(input logic [7:0] b);
    feed_t f;
    f = '0;
    f.ev = EV_BYTE;
    f.rx = b;
    feed_q.push_back(f);
    items_queued++;
  endtask

  task automatic add_timeout();
    feed_t f;
    f = '0;
    f.ev = EV_TIMEOUT;
    f.rx = 8'($urandom_range(0, 255));
    feed_q.push_back(f);
    items_queued++;
  endtask

  task automatic add_cfg(input logic idx, input logic [9:0] data);
    feed_t f;
    f = '0;
    f.is_cfg = 1'b1;
    f.idx = idx;
    f.data = data;
    feed_q.push_back(f);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 5))
      0: return CH_A;
      1: return CH_B;
      2: return CH_C;
      3: return CH_D;
      4: return CH_H;
      default: return CH_F;
    endcase
  endfunction

  function automatic logic [9:0] pick_size();
    case ($urandom_range(0, 4))
      0, 1: return 10'($urandom_range(1, 8));
      2: return 10'($urandom_range(0, 1023));
      3: return 10'd1023;
      default: return 10'd0;
    endcase
  endfunction

  task automatic add_random_sequence();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      add_byte(ESC_BYTE);
      add_byte(LBRK_BYTE);
      if ($urandom_range(0, 6) == 0) add_byte(8'($urandom_range(0, 255)));
      else add_byte(pick_letter());
    end else if (pick < 45) begin
      add_byte(ESC_BYTE);
      add_byte(OH_BYTE);
      if ($urandom_range(0, 6) == 0) add_byte(8'($urandom_range(0, 255)));
      else add_byte(pick_letter());
    end else if (pick < 65) begin
      add_byte(ESC_BYTE);
      add_byte(LBRK_BYTE);
      add_byte(8'($urandom_range(CH_0, CH_9)));
      pick = $urandom_range(0, 19);
      if (pick < 15) add_byte(TILDE_BYTE);
      else if (pick < 18) add_byte(8'($urandom_range(0, 255)));
      else add_timeout();
    end else if (pick < 80) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) add_byte(QUIT_BYTE);
      else add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      // broken sequence, possibly cut short by a timeout
      add_byte(ESC_BYTE);
      if ($urandom_range(0, 2) == 0) begin
        add_timeout();
      end else begin
        add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0) add_timeout();
        else add_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      add_timeout();
    end
  endtask

  initial begin
    int unsigned target;
    // directed: extremes, quit, every sequence shape, timeouts idle and mid-sequence
    add_timeout();
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(QUIT_BYTE);
    add_byte(ESC_BYTE); add_byte(LBRK_BYTE); add_byte(CH_A);
    add_byte(ESC_BYTE); add_byte(OH_BYTE); add_byte(CH_H);
    add_byte(ESC_BYTE); add_byte(LBRK_BYTE); add_byte(CH_3); add_byte(TILDE_BYTE);
    add_byte(ESC_BYTE); add_byte(LBRK_BYTE); add_byte(CH_5); add_byte(CH_A);
    add_byte(ESC_BYTE); add_timeout();
    add_byte(ESC_BYTE); add_byte(ESC_BYTE); add_byte(ESC_BYTE);
    add_byte(ESC_BYTE); add_byte(OH_BYTE); add_byte(CH_A);

    target = items_queued;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin add_cfg(REG_ROWS, 10'd1023); add_cfg(REG_COLS, 10'd1023); end
        1: begin add_cfg(REG_ROWS, 10'd1); add_cfg(REG_COLS, 10'd1); end
        2: begin add_cfg(REG_ROWS, 10'd0); add_cfg(REG_COLS, 10'd0); end
        3: begin add_cfg(REG_ROWS, 10'd2); add_cfg(REG_COLS, 10'd3); end
        default: begin add_cfg(REG_ROWS, pick_size()); add_cfg(REG_COLS, pick_size()); end
      endcase
      target += PHASE_ITEMS;
      while (items_queued < target) add_random_sequence();
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // sample at the falling edge so the clocked blocks have settled
    @(negedge clk);
    while (feed_q.size() != 0 || push) @(negedge clk);
    while (keys_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tkd_pkg.sv
hdl/tkd_front.sv
hdl/tkd_keyq.sv
hdl/tkd_back.sv
hdl/terminal_key_decoder_cursor.sv
verif/tb.sv
